@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros shared by the queue rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define DQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define DQ_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/core/dq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dq_pkg
// shared constants, codes, types and ring address helpers for the deque
// ---------------------------------------------------------------------------
package dq_pkg;

	// sizes
	localparam int DEPTH   = 256;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int POS_W   = 16;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;
	localparam int SUM_W   = ADDR_W + 1;
	localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_IDX   = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE_IDX  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
	} dq_cmd_t;

	// physical slot of a logical offset from the head, offset below DEPTH
	function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
			input logic [SUM_W-1:0] offset);
		logic [SUM_W-1:0] sum;
		begin
			sum = SUM_W'(head) + offset;
			if (sum >= SUM_W'(DEPTH)) begin
				sum = sum - SUM_W'(DEPTH);
			end
			slot_of = sum[ADDR_W-1:0];
		end
	endfunction

	// head pointer moved one slot towards the front with wrap
	function automatic logic [ADDR_W-1:0] head_dec(input logic [ADDR_W-1:0] head);
		begin
			if (head == '0) begin
				head_dec = ADDR_W'(DEPTH - 1);
			end else begin
				head_dec = head - 1'b1;
			end
		end
	endfunction

endpackage

@@ rtl/core/dq_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dq_ram
// generic single port ram, one write or one registered read per cycle
// ---------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/dq_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dq_ctrl
// request sequencer: capture, execute against the ring, present the result
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_ctrl
	import dq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    done,
	output dq_cmd_t cmd
);

	localparam int STATE_W = 2;
	localparam logic [STATE_W-1:0] S_IDLE = 2'd0;
	localparam logic [STATE_W-1:0] S_EXEC = 2'd1;
	localparam logic [STATE_W-1:0] S_RESP = 2'd2;

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] state_d;
	logic               accept;

	// a request is taken whenever the ring is not being worked on
	assign busy   = (state_q == S_EXEC);
	assign accept = start && !busy;
	assign done   = (state_q == S_RESP);

	assign cmd = '{capture: accept, exec: (state_q == S_EXEC)};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = accept ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`DQ_ASSERT(a_accept_to_done, clk, arst_n, (accept |=> busy ##1 done), "request without result")
	`DQ_ASSERT(a_done_after_exec, clk, arst_n, (done |-> $past(busy)), "result without execution")
	`DQ_NEVER(a_busy_and_done, clk, arst_n, (busy && done), "busy during result")

endmodule

@@ rtl/core/dq_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dq_dp
// datapath: request registers, head pointer, occupancy and ring store
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_dp
	import dq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  dq_cmd_t                  cmd,
	input  logic [OP_W-1:0]          operation,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] data_in,
	output logic signed [DATA_W-1:0] data_out,
	output logic [CNT_W-1:0]         element_count,
	output logic [STAT_W-1:0]        status
);

	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] data_q;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [STAT_W-1:0] status_q;
	logic              rd_ok_q;

	logic [ADDR_W-1:0] head_d;
	logic [CNT_W-1:0]  count_d;
	logic [STAT_W-1:0] status_d;
	logic              rd_ok_d;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [DATA_W-1:0] ram_rdata;
	logic              full;
	logic              empty;
	logic              in_range;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			pos_q  <= position;
			data_q <= data_in;
		end
	end

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = (CMP_W'(pos_q) < CMP_W'(count_q));

	// operation decode and ring addressing
	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = STAT_OK;
		rd_ok_d  = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = head_q;
		unique case (op_q)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					head_d   = head_dec(head_q);
					ram_addr = head_dec(head_q);
					ram_we   = cmd.exec;
					count_d  = count_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					ram_addr = slot_of(head_q, SUM_W'(count_q));
					ram_we   = cmd.exec;
					count_d  = count_q + 1'b1;
				end
			end
			OP_READ_IDX: begin
				if (!in_range) begin
					status_d = STAT_RANGE;
				end else begin
					ram_addr = slot_of(head_q, SUM_W'(pos_q));
					ram_re   = cmd.exec;
					rd_ok_d  = 1'b1;
				end
			end
			OP_WRITE_IDX: begin
				if (!in_range) begin
					status_d = STAT_RANGE;
				end else begin
					ram_addr = slot_of(head_q, SUM_W'(pos_q));
					ram_we   = cmd.exec;
				end
			end
			OP_READ_FRONT: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					ram_re  = cmd.exec;
					rd_ok_d = 1'b1;
				end
			end
			OP_READ_BACK: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					ram_addr = slot_of(head_q, SUM_W'(count_q - 1'b1));
					ram_re   = cmd.exec;
					rd_ok_d  = 1'b1;
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// pointer, occupancy and result status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			status_q <= STAT_OK;
			rd_ok_q  <= 1'b0;
		end else if (cmd.exec) begin
			head_q   <= head_d;
			count_q  <= count_d;
			status_q <= status_d;
			rd_ok_q  <= rd_ok_d;
		end
	end

	// ring store
	dq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (data_q),
		.rdata (ram_rdata)
	);

	// result
	assign data_out      = rd_ok_q ? $signed(ram_rdata) : '0;
	assign element_count = count_q;
	assign status        = status_q;

	`DQ_NEVER(a_count_bound, clk, arst_n, (count_q > CNT_W'(DEPTH)), "occupancy beyond depth")
	`DQ_ASSERT(a_full_status, clk, arst_n, ((status_q == STAT_FULL) |-> full), "full status below depth")
	`DQ_NEVER(a_read_with_error, clk, arst_n, (rd_ok_q && (status_q != STAT_OK)), "read on error")

endmodule

@@ rtl/core/double_ended_queue_top.sv @@
`timescale 1ns / 1ps
// a request accepted at one edge is captured, executed in S_EXEC and its result strobe is given in S_RESP
// no request is taken while busy in S_EXEC; the single port ring ram has a registered read
// a new request is taken in the same cycle that the previous result is on the ports
// the receiver cannot stall; done marks each result for exactly one cycle
// reset: queue empty, head at slot zero, sequencer idle; ring contents are left as they are
// ---------------------------------------------------------------------------
// double_ended_queue_top
// bounded deque of signed words held in a ring ram, one result per request
// ---------------------------------------------------------------------------
module double_ended_queue_top
	import dq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          operation,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] data_in,
	output logic                     done,
	output logic signed [DATA_W-1:0] data_out,
	output logic [CNT_W-1:0]         element_count,
	output logic [STAT_W-1:0]        status
);

	dq_cmd_t cmd;

	// sequencer
	dq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// ring datapath
	dq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (operation),
		.position      (position),
		.data_in       (data_in),
		.data_out      (data_out),
		.element_count (element_count),
		.status        (status)
	);

endmodule
